// File: rtl/fdw5_pkg.sv
// Shared types, constants and probe tables for the 5x5 flow direction block.
package fdw5_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;
   localparam int DIST_BITS_DEFAULT  = 16;

   // Fixed widths of the ports and of internal coordinate math
   localparam int CELL_BITS  = 8;
   localparam int SIZE_BITS  = 13;   // holds a grid size up to 4096
   localparam int COORD_BITS = 11;   // signed cell coordinate plus offset
   localparam int CSR_BITS   = 9;
   localparam int REQ_DIST_BITS = 16;
   localparam int CODE_BITS  = 8;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // Probe sequence: the cell itself, then 24 neighbors in scan order
   localparam int PROBE_COUNT = 25;
   localparam int PROBE_BITS  = 5;
   localparam logic [PROBE_BITS-1:0] PROBE_SELF        = 5'd0;
   localparam logic [PROBE_BITS-1:0] PROBE_DIAG_FIRST  = 5'd5;
   localparam logic [PROBE_BITS-1:0] PROBE_OUTER_FIRST = 5'd9;
   localparam logic [PROBE_BITS-1:0] PROBE_LAST        = 5'd24;

   localparam logic [CODE_BITS-1:0] NO_DIR = 8'd255;

   localparam logic signed [2:0] OFF_X [PROBE_COUNT] = '{
      3'sd0,
      -3'sd1, 3'sd1, 3'sd0, 3'sd0,
      -3'sd1, 3'sd1, -3'sd1, 3'sd1,
      -3'sd2, 3'sd2, 3'sd0, 3'sd0, -3'sd2, 3'sd2, -3'sd2, 3'sd2,
      -3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd2, 3'sd2, -3'sd1, 3'sd1
   };

   localparam logic signed [2:0] OFF_Y [PROBE_COUNT] = '{
      3'sd0,
      3'sd0, 3'sd0, 3'sd1, -3'sd1,
      -3'sd1, -3'sd1, 3'sd1, 3'sd1,
      3'sd0, 3'sd0, 3'sd2, -3'sd2, -3'sd2, -3'sd2, 3'sd2, 3'sd2,
      -3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2
   };

   localparam logic [CODE_BITS-1:0] DIR_CODE [PROBE_COUNT] = '{
      8'd255,
      8'd7, 8'd8, 8'd11, 8'd4,
      8'd3, 8'd5, 8'd10, 8'd12,
      8'd7, 8'd8, 8'd11, 8'd4,
      8'd3, 8'd5, 8'd10, 8'd12,
      8'd0, 8'd1, 8'd2, 8'd6,
      8'd9, 8'd13, 8'd14, 8'd15
   };

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted item, restart the scan
      logic write;   // store the captured distance
      logic scan;    // issue probes and evaluate returned cells
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic done;    // query ends with this evaluation; the code register then holds the answer
   } dp_status_type;

endpackage

// File: rtl/flow_direction_window_five.sv
// Top level of the 5x5 steepest-descent flow direction block.
//
// A write item stores its distance and returns the block to idle. A query item reads
// the cell and its 24 neighbors one per cycle from the single-port distance store and
// raises rsp_valid once the scan ends: after the last neighbor is evaluated at most,
// and sooner when the scan stops early at a ring boundary or when the queried cell is
// outside the grid, a target or a wall. busy is low only while the block waits for
// an item. The receiver cannot
// stall: rsp_direction_code is valid for the single cycle rsp_valid is high. Grid
// size writes on the csr_ port are taken in any cycle and are meant for idle times.
module flow_direction_window_five
   import fdw5_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
   parameter int DIST_BITS  = DIST_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_command,
   input  logic [CELL_BITS-1:0]     req_cell_x,
   input  logic [CELL_BITS-1:0]     req_cell_y,
   input  logic [REQ_DIST_BITS-1:0] req_distance,
   output logic                     rsp_valid,
   output logic [CODE_BITS-1:0]     rsp_direction_code,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [CSR_BITS-1:0]      csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fdw5_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   fdw5_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DIST_BITS  (DIST_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cell_x         (req_cell_x),
      .req_cell_y         (req_cell_y),
      .req_distance       (req_distance),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_direction_code (rsp_direction_code)
   );

endmodule

// File: rtl/fdw5_ctrl.sv
// Controller state machine for the flow direction block.
module fdw5_ctrl
   import fdw5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_command,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_command == CMD_WRITE) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/fdw5_datapath.sv
// Datapath: grid size registers, distance store, probe issue and neighbor evaluation.
module fdw5_datapath
   import fdw5_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
   parameter int DIST_BITS  = DIST_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [CELL_BITS-1:0]     req_cell_x,
   input  logic [CELL_BITS-1:0]     req_cell_y,
   input  logic [REQ_DIST_BITS-1:0] req_distance,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [CSR_BITS-1:0]      csr_write_data,
   output logic [CODE_BITS-1:0]     rsp_direction_code
);

   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam logic [ADDR_BITS-1:0] ROW_STRIDE = ADDR_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] MAX_W      = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] MAX_H      = SIZE_BITS'(MAX_HEIGHT);
   localparam logic [DIST_BITS-1:0] WALL       = {DIST_BITS{1'b1}};

   // Configuration registers
   logic [CSR_BITS-1:0] grid_width_ff;
   logic [CSR_BITS-1:0] grid_height_ff;

   // Captured item
   logic [CELL_BITS-1:0] x_ff;
   logic [CELL_BITS-1:0] y_ff;
   logic [DIST_BITS-1:0] dist_ff;

   // Probe issue and evaluation stage
   logic [PROBE_BITS-1:0] probe_ff;
   logic                  ev_valid_ff;
   logic [PROBE_BITS-1:0] ev_idx_ff;
   logic                  ev_in_ff;
   logic [DIST_BITS-1:0]  rd_data_ff;

   // Scan results
   logic [DIST_BITS-1:0] best_ff;
   logic                 any_wall_ff;
   logic [CODE_BITS-1:0] code_ff;

   logic [DIST_BITS-1:0] mem [DEPTH];

   logic [SIZE_BITS-1:0]         w_eff;
   logic [SIZE_BITS-1:0]         h_eff;
   logic signed [COORD_BITS-1:0] nx;
   logic signed [COORD_BITS-1:0] ny;
   logic                         probe_in;
   logic                         issue;
   logic                         write_ok;
   logic [ADDR_BITS-1:0]         probe_addr;
   logic [ADDR_BITS-1:0]         write_addr;
   logic                         ev_go;
   logic                         ev_wall;
   logic                         ev_lower;
   logic                         ring_stop;

   // Clamp the sizes in use to 1..MAX
   always_comb begin
      w_eff = SIZE_BITS'(grid_width_ff);
      if (w_eff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (w_eff > MAX_W) begin
         w_eff = MAX_W;
      end
      h_eff = SIZE_BITS'(grid_height_ff);
      if (h_eff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (h_eff > MAX_H) begin
         h_eff = MAX_H;
      end
   end

   // Probe coordinates, grid check and store addresses
   always_comb begin
      nx = $signed({3'b000, x_ff}) + {{(COORD_BITS-3){OFF_X[probe_ff][2]}}, OFF_X[probe_ff]};
      ny = $signed({3'b000, y_ff}) + {{(COORD_BITS-3){OFF_Y[probe_ff][2]}}, OFF_Y[probe_ff]};
      probe_in = !nx[COORD_BITS-1] && !ny[COORD_BITS-1]
                 && (SIZE_BITS'(nx[COORD_BITS-2:0]) < w_eff)
                 && (SIZE_BITS'(ny[COORD_BITS-2:0]) < h_eff);
      probe_addr = ADDR_BITS'(ADDR_BITS'(ny[COORD_BITS-2:0]) * ROW_STRIDE)
                   + ADDR_BITS'(nx[COORD_BITS-2:0]);
      write_ok = (SIZE_BITS'(x_ff) < MAX_W) && (SIZE_BITS'(y_ff) < MAX_H);
      write_addr = ADDR_BITS'(ADDR_BITS'(y_ff) * ROW_STRIDE) + ADDR_BITS'(x_ff);
      issue = cmd.scan && (probe_ff <= PROBE_LAST);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 9'd256;
         grid_height_ff <= 9'd256;
      end else if (csr_write_en) begin
         if (csr_index == REG_GRID_WIDTH) begin
            grid_width_ff <= csr_write_data;
         end else begin
            grid_height_ff <= csr_write_data;
         end
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_cell_x;
         y_ff    <= req_cell_y;
         dist_ff <= DIST_BITS'(req_distance);
      end
   end

   // Single-port distance store
   always_ff @(posedge clock) begin
      if (cmd.write && write_ok) begin
         mem[write_addr] <= dist_ff;
      end
      rd_data_ff <= mem[issue ? probe_addr : write_addr];
   end

   // Advance the probe counter and the evaluation stage
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff    <= '0;
         ev_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         probe_ff    <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            probe_ff <= probe_ff + 1'b1;
         end
         ev_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= probe_ff;
      ev_in_ff  <= probe_in;
   end

   // Evaluate the returned cell
   always_comb begin
      ev_go     = ev_valid_ff && cmd.scan;
      ev_wall   = (rd_data_ff == WALL);
      ev_lower  = (rd_data_ff < best_ff);
      ring_stop = ((ev_idx_ff == PROBE_DIAG_FIRST) || (ev_idx_ff == PROBE_OUTER_FIRST))
                  && any_wall_ff;
      status.done = 1'b0;
      if (ev_go) begin
         if (ev_idx_ff == PROBE_SELF) begin
            status.done = !ev_in_ff || (rd_data_ff == '0) || ev_wall;
         end else begin
            status.done = ring_stop || (ev_idx_ff == PROBE_LAST);
         end
      end
   end

   // Track best value, wall flag and direction code
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff     <= NO_DIR;
         any_wall_ff <= 1'b0;
      end else if (ev_go) begin
         if (ev_idx_ff == PROBE_SELF) begin
            best_ff <= rd_data_ff;
         end else if (!ring_stop) begin
            if (!ev_in_ff) begin
               any_wall_ff <= 1'b1;
            end else begin
               if (ev_wall) begin
                  any_wall_ff <= 1'b1;
               end
               if (ev_lower) begin
                  best_ff <= rd_data_ff;
                  code_ff <= DIR_CODE[ev_idx_ff];
               end
            end
         end
      end
   end

   assign rsp_direction_code = code_ff;

endmodule

// File: tb/flow_direction_window_five_tb.sv
// Self-checking testbench for the 5x5 flow direction block: directed and random grid loads and queries.
`timescale 1ns / 1ps

module flow_direction_window_five_tb;
   import fdw5_pkg::*;

   localparam int STORE_SIDE    = 256;
   localparam int SCAN_LEN      = 24;
   localparam int IDLE_SETTLE   = 40;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int PHASE_COUNT   = 11;
   localparam int PHASE_BUDGET  = 100;
   localparam logic [15:0] WALL = 16'hFFFF;

   // Neighbor scan: orthogonal ring, diagonal ring, then the sixteen cells two away
   localparam int SCAN_DX [SCAN_LEN] = '{
      -1, 1, 0, 0, -1, 1, -1, 1,
      -2, 2, 0, 0, -2, 2, -2, 2, -1, 1, -2, 2, -2, 2, -1, 1
   };
   localparam int SCAN_DY [SCAN_LEN] = '{
      0, 0, 1, -1, -1, -1, 1, 1,
      0, 0, 2, -2, -2, -2, 2, 2, -2, -2, -1, -1, 1, 1, 2, 2
   };
   localparam int SCAN_CODE [SCAN_LEN] = '{
      7, 8, 11, 4, 3, 5, 10, 12,
      7, 8, 11, 4, 3, 5, 10, 12, 0, 1, 2, 6, 9, 13, 14, 15
   };

   // Grid settings walked through after the directed part, extremes included
   localparam logic [CSR_BITS-1:0] PHASE_W [PHASE_COUNT] = '{
      9'd256, 9'd8, 9'd1, 9'd0, 9'd511, 9'd5, 9'd1, 9'd16, 9'd256, 9'd2, 9'd40
   };
   localparam logic [CSR_BITS-1:0] PHASE_H [PHASE_COUNT] = '{
      9'd256, 9'd8, 9'd1, 9'd0, 9'd300, 9'd1, 9'd7, 9'd12, 9'd5, 9'd256, 9'd40
   };

   // Directed 3x3 grid, row by row
   localparam logic [REQ_DIST_BITS-1:0] DIRECTED_GRID [9] = '{
      16'd5, 16'd3, 16'd7,
      16'd4, 16'd6, 16'd2,
      16'd0, WALL,  16'd9
   };

   typedef struct packed {
      logic                     command;
      logic [CELL_BITS-1:0]     cell_x;
      logic [CELL_BITS-1:0]     cell_y;
      logic [REQ_DIST_BITS-1:0] distance;
   } grid_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_command = CMD_WRITE;
   logic [CELL_BITS-1:0]     req_cell_x = '0;
   logic [CELL_BITS-1:0]     req_cell_y = '0;
   logic [REQ_DIST_BITS-1:0] req_distance = '0;
   logic                     rsp_valid;
   logic [CODE_BITS-1:0]     rsp_direction_code;
   logic                     csr_write_en = 1'b0;
   logic                     csr_index = REG_GRID_WIDTH;
   logic [CSR_BITS-1:0]      csr_write_data = '0;

   // Predicted grid contents and the grid size registers
   logic [REQ_DIST_BITS-1:0] dist_mem [0:STORE_SIDE*STORE_SIDE-1];
   logic [CSR_BITS-1:0]      grid_cols_reg = 9'd256;
   logic [CSR_BITS-1:0]      grid_rows_reg = 9'd256;

   // Cells that some queued write has covered, tracked while items are generated
   bit planned [0:STORE_SIDE*STORE_SIDE-1];

   grid_item_type      pending_items [$];
   logic [CODE_BITS-1:0] expected_codes [$];
   logic [CODE_BITS-1:0] expected_code;
   grid_item_type      held_item;
   bit                 launch;
   int                 gap_left = 0;
   int                 burst_left = 0;
   int                 queued_items = 0;
   int                 accepted_items = 0;
   int                 phase_items = 0;
   int                 writes_seen = 0;
   int                 queries_seen = 0;
   int                 results_checked = 0;
   int                 mismatch_count = 0;
   int                 phases_run = 0;
   int                 cycle_count = 0;

   flow_direction_window_five i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_cell_x         (req_cell_x),
      .req_cell_y         (req_cell_y),
      .req_distance       (req_distance),
      .rsp_valid          (rsp_valid),
      .rsp_direction_code (rsp_direction_code),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Clamp a size register to the range the store supports
   function automatic int grid_extent(logic [CSR_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > STORE_SIDE) return STORE_SIDE;
      return int'(v);
   endfunction

   // Steepest-descent code for one cell under the current grid size
   function automatic logic [CODE_BITS-1:0] predict_direction(int x, int y);
      int w, h, nx, ny;
      logic [REQ_DIST_BITS-1:0] own, best, v;
      logic [CODE_BITS-1:0] code;
      bit saw_wall, stopped;
      w = grid_extent(grid_cols_reg);
      h = grid_extent(grid_rows_reg);
      if (x >= w || y >= h) return NO_DIR;
      own = dist_mem[y*STORE_SIDE + x];
      if (own == 16'h0000 || own == WALL) return NO_DIR;
      best = own;
      code = NO_DIR;
      saw_wall = 1'b0;
      stopped = 1'b0;
      for (int i = 0; i < SCAN_LEN; i++) begin
         // stop at a ring boundary once a wall or the grid edge was seen
         if ((i == 4 || i == 8) && saw_wall) stopped = 1'b1;
         if (!stopped) begin
            nx = x + SCAN_DX[i];
            ny = y + SCAN_DY[i];
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
               v = dist_mem[ny*STORE_SIDE + nx];
               if (v == WALL) saw_wall = 1'b1;
               if (v < best) begin
                  best = v;
                  code = CODE_BITS'(SCAN_CODE[i]);
               end
            end else begin
               saw_wall = 1'b1;
            end
         end
      end
      return code;
   endfunction

   // Update the grid or queue the predicted code for one accepted item
   task automatic apply_item(grid_item_type item);
      if (item.command == CMD_WRITE) begin
         dist_mem[int'(item.cell_y)*STORE_SIDE + int'(item.cell_x)] = item.distance;
         writes_seen++;
      end else begin
         expected_codes.push_back(predict_direction(int'(item.cell_x), int'(item.cell_y)));
         queries_seen++;
      end
   endtask

   // Mostly short gaps, a few long ones, and bursts with none
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 30);
      return $urandom_range(31, 70);
   endfunction

   function automatic logic [REQ_DIST_BITS-1:0] pick_distance(logic [REQ_DIST_BITS-1:0] base);
      int r;
      r = $urandom_range(0, 99);
      if (r < 7) return WALL;
      if (r < 12) return 16'h0000;
      if (r < 22) return REQ_DIST_BITS'($urandom);
      if (r < 25) return 16'hFFFE;
      return base + REQ_DIST_BITS'($urandom_range(0, 12));
   endfunction

   task automatic push_write(int x, int y, logic [REQ_DIST_BITS-1:0] d);
      pending_items.push_back('{CMD_WRITE, CELL_BITS'(x), CELL_BITS'(y), d});
      planned[y*STORE_SIDE + x] = 1'b1;
      queued_items++;
      phase_items++;
   endtask

   task automatic push_query(int x, int y);
      pending_items.push_back('{CMD_QUERY, CELL_BITS'(x), CELL_BITS'(y),
                                REQ_DIST_BITS'($urandom)});
      queued_items++;
      phase_items++;
   endtask

   // A query may go out only if every in-grid cell it can read was written
   function automatic bit query_safe(int x, int y);
      int w, h, nx, ny;
      w = grid_extent(grid_cols_reg);
      h = grid_extent(grid_rows_reg);
      if (x >= w || y >= h) return 1'b1;
      for (int oy = -2; oy <= 2; oy++) begin
         for (int ox = -2; ox <= 2; ox++) begin
            nx = x + ox;
            ny = y + oy;
            if (nx >= 0 && nx < w && ny >= 0 && ny < h && !planned[ny*STORE_SIDE + nx])
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Fill a 5x5 window with random distances, query inside it, and sometimes add a stray item
   task automatic build_sequence();
      int w, h, cx, cy, nx, ny, qx, qy, r, n;
      bit partial;
      logic [REQ_DIST_BITS-1:0] base;
      w = grid_extent(grid_cols_reg);
      h = grid_extent(grid_rows_reg);
      base = REQ_DIST_BITS'($urandom_range(1, 200));
      partial = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
         cx = $urandom_range(0, (w < 12) ? w - 1 : 11);
         cy = $urandom_range(0, (h < 12) ? h - 1 : 11);
      end else if (r < 80) begin
         cx = w - 1 - $urandom_range(0, (w < 3) ? w - 1 : 2);
         cy = $urandom_range(0, 1) ? h - 1 - $urandom_range(0, (h < 3) ? h - 1 : 2)
                                   : $urandom_range(0, h - 1);
      end else if (r < 92) begin
         cx = $urandom_range(0, w - 1);
         cy = $urandom_range(0, h - 1);
      end else begin
         cx = $urandom_range(0, STORE_SIDE - 1);
         cy = $urandom_range(0, STORE_SIDE - 1);
      end
      // load the window, rewriting some cells that already hold a value
      for (int oy = -2; oy <= 2; oy++) begin
         for (int ox = -2; ox <= 2; ox++) begin
            nx = cx + ox;
            ny = cy + oy;
            if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
                (!planned[ny*STORE_SIDE + nx] || $urandom_range(0, 3) == 0) &&
                !(partial && $urandom_range(0, 1) == 1))
               push_write(nx, ny, pick_distance(base));
         end
      end
      // query around the center; fall back to the center, or drop a query that would read an unwritten cell
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
         qx = cx + $urandom_range(0, 4) - 2;
         qy = cy + $urandom_range(0, 4) - 2;
         if (qx < 0) qx = 0;
         if (qy < 0) qy = 0;
         if (qx >= STORE_SIDE) qx = STORE_SIDE - 1;
         if (qy >= STORE_SIDE) qy = STORE_SIDE - 1;
         if (!query_safe(qx, qy)) begin
            qx = cx;
            qy = cy;
         end
         if (query_safe(qx, qy)) push_query(qx, qy);
      end
      // stray write or query anywhere in the store
      r = $urandom_range(0, 99);
      if (r < 15) begin
         push_write($urandom_range(0, STORE_SIDE - 1), $urandom_range(0, STORE_SIDE - 1),
                    REQ_DIST_BITS'($urandom));
      end else if (r < 22) begin
         qx = $urandom_range(0, STORE_SIDE - 1);
         qy = $urandom_range(0, STORE_SIDE - 1);
         if (query_safe(qx, qy)) push_query(qx, qy);
      end
   endtask

   // Hold until every item is taken and answered, then let the block settle
   task automatic wait_for_idle();
      while (accepted_items != queued_items || expected_codes.size() != 0 || busy !== 1'b0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic set_grid(logic [CSR_BITS-1:0] width, logic [CSR_BITS-1:0] height);
      wait_for_idle();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= REG_GRID_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      csr_index      <= REG_GRID_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      grid_cols_reg = width;
      grid_rows_reg = height;
      phases_run++;
   endtask

   // Driver: present queued items, retire each one as the block accepts it
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         launch = start;
         if (start && !busy) begin
            apply_item(held_item);
            accepted_items++;
            launch = 1'b0;
            gap_left = pick_gap();
         end
         if (!launch) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               held_item = pending_items.pop_front();
               req_command  <= held_item.command;
               req_cell_x   <= held_item.cell_x;
               req_cell_y   <= held_item.cell_y;
               req_distance <= held_item.distance;
               launch = 1'b1;
            end
         end
         start <= launch;
      end
   end

   // Monitor: compare each strobed code with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_codes.size() == 0) begin
            $error("direction_code: expected none, actual %0d", rsp_direction_code);
            mismatch_count++;
         end else begin
            expected_code = expected_codes.pop_front();
            if (rsp_direction_code !== expected_code) begin
               $error("direction_code: expected %0d, actual %0d",
                      expected_code, rsp_direction_code);
               mismatch_count++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $error("run stopped after %0d cycles with %0d codes outstanding",
                cycle_count, expected_codes.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x3 grid holding a target, a wall, a local minimum and descents
      set_grid(9'd3, 9'd3);
      for (int i = 0; i < 9; i++) push_write(i % 3, i / 3, DIRECTED_GRID[i]);
      for (int i = 0; i < 9; i++) push_query(i % 3, i / 3);
      // stored outside the grid in use, queries outside the grid
      push_write(255, 255, 16'hFFFE);
      push_query(255, 255);
      push_query(5, 0);
      push_query(0, 7);

      // Random: grid settings from clamped zero to oversize
      for (int p = 0; p < PHASE_COUNT + 2; p++) begin
         if (p < PHASE_COUNT)
            set_grid(PHASE_W[p], PHASE_H[p]);
         else
            set_grid(CSR_BITS'($urandom_range(1, 64)), CSR_BITS'($urandom_range(1, 64)));
         phase_items = 0;
         while (phase_items < PHASE_BUDGET) build_sequence();
      end

      wait_for_idle();
      if (expected_codes.size() != 0) begin
         $error("direction_code: %0d expected codes never arrived", expected_codes.size());
         mismatch_count++;
      end
      $display("Covered %0d grid sizes: %0d distance writes, %0d direction queries,",
               phases_run, writes_seen, queries_seen);
      $display("%0d direction codes compared, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
